// File: src/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned KeyDepth  = 256;
  localparam int unsigned KeyLenW   = $clog2(KeyDepth + 1);
  localparam int unsigned KeyAddrW  = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam int unsigned PermDepth = 256;
  localparam int unsigned ByteW     = 8;

  localparam logic OpKey  = 1'b0;
  localparam logic OpData = 1'b1;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [ByteW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic [ByteW-1:0] raddr;
  } perm_req_t;

  typedef struct packed {
    logic                we;
    logic [KeyAddrW-1:0] waddr;
    logic [ByteW-1:0]    wdata;
    logic [KeyAddrW-1:0] raddr;
  } key_req_t;

endpackage

// File: src/rc4_keystream_cipher.sv
// RC4 stream cipher. Send key bytes with tuser low and mark the final one with tlast; that
// transfer starts the key schedule, during which no input is taken. Each swap step runs through
// StKRd, StKAdd, StKWa and StKWb, bound by the single read port of the permutation memory.
// Key bytes without tlast are stored without leaving idle; bytes past the key store depth are
// dropped. Data bytes (tuser high) pass through StIdle, StDRdJ, StDSwp and StDOut: read S[i],
// read S[j], swap and read S[S[i]+S[j]], all through the one permutation memory. Each data
// byte gives one output transfer carrying the XOR result and the keystream byte; a registered
// output stage lets the next byte be taken while a result waits. Data sent before any key
// uses the identity permutation, restored by per-entry valid bits, so no clearing pass is needed.
module rc4_keystream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_key
  input  logic        s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] out_byte, [15:8] keystream_byte
);
  import rc4_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDRdJ = 3'd1;
  localparam logic [2:0] StDSwp = 3'd2;
  localparam logic [2:0] StDOut = 3'd3;
  localparam logic [2:0] StKRd  = 3'd4;
  localparam logic [2:0] StKAdd = 3'd5;
  localparam logic [2:0] StKWa  = 3'd6;
  localparam logic [2:0] StKWb  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [ByteW-1:0]    i_q, i_d, j_q, j_d;
  logic [ByteW-1:0]    si_q, si_d, sj_q, sj_d, t_q, t_d, byte_q, byte_d;
  logic [ByteW-1:0]    k_q, k_d, acc_q, acc_d;
  logic [KeyAddrW-1:0] kidx_q, kidx_d;
  logic [KeyLenW-1:0]  key_len_q, key_len_d;
  logic                out_vld_q, out_vld_d;
  logic [15:0]         out_q, out_d;

  perm_req_t        perm_req;
  key_req_t         key_req;
  logic [ByteW-1:0] perm_rdata;
  logic [ByteW-1:0] key_rdata;
  logic [ByteW-1:0] ks;
  logic             in_xfer;
  logic             out_free;

  rc4_perm_mem u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

  rc4_key_mem u_key (
    .clk_i   (clk_i),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // S[t] after the swap; the two swapped entries are forwarded
  always_comb begin
    if (t_q == i_q) begin
      ks = sj_q;
    end else if (t_q == j_q) begin
      ks = si_q;
    end else begin
      ks = perm_rdata;
    end
  end

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    si_d      = si_q;
    sj_d      = sj_q;
    t_d       = t_q;
    byte_d    = byte_q;
    k_d       = k_q;
    acc_d     = acc_q;
    kidx_d    = kidx_q;
    key_len_d = key_len_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_d     = out_q;

    perm_req       = '0;
    perm_req.raddr = i_q + 8'd1;
    key_req        = '0;
    key_req.raddr  = kidx_q;
    key_req.waddr  = key_len_q[KeyAddrW-1:0];
    key_req.wdata  = s_axis_tdata_i;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser_i == OpData) begin
            i_d     = i_q + 8'd1;
            byte_d  = s_axis_tdata_i;
            state_d = StDRdJ;
          end else begin
            if (key_len_q < KeyLenW'(KeyDepth)) begin
              key_req.we = 1'b1;
              key_len_d  = key_len_q + 1'b1;
            end
            if (s_axis_tlast_i) begin
              perm_req.clr = 1'b1;
              k_d          = '0;
              kidx_d       = '0;
              acc_d        = '0;
              state_d      = StKRd;
            end
          end
        end
      end
      StDRdJ: begin
        si_d           = perm_rdata;
        j_d            = j_q + perm_rdata;
        perm_req.raddr = j_q + perm_rdata;
        state_d        = StDSwp;
      end
      StDSwp: begin
        sj_d           = perm_rdata;
        perm_req.we    = 1'b1;
        perm_req.waddr = i_q;
        perm_req.wdata = perm_rdata;
        t_d            = si_q + perm_rdata;
        perm_req.raddr = si_q + perm_rdata;
        state_d        = StDOut;
      end
      StDOut: begin
        perm_req.raddr = t_q;
        if (out_free) begin
          perm_req.we    = 1'b1;
          perm_req.waddr = j_q;
          perm_req.wdata = si_q;
          out_vld_d      = 1'b1;
          out_d          = {ks, byte_q ^ ks};
          state_d        = StIdle;
        end
      end
      StKRd: begin
        perm_req.raddr = k_q;
        state_d        = StKAdd;
      end
      StKAdd: begin
        si_d           = perm_rdata;
        acc_d          = acc_q + perm_rdata + key_rdata;
        perm_req.raddr = acc_q + perm_rdata + key_rdata;
        state_d        = StKWa;
      end
      StKWa: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = k_q;
        perm_req.wdata = perm_rdata;
        state_d        = StKWb;
      end
      StKWb: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = acc_q;
        perm_req.wdata = si_q;
        k_d            = k_q + 8'd1;
        if (KeyLenW'(kidx_q) + 1'b1 == key_len_q) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + 1'b1;
        end
        if (k_q == 8'hff) begin
          i_d       = '0;
          j_d       = '0;
          key_len_d = '0;
          state_d   = StIdle;
        end else begin
          state_d = StKRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      acc_q     <= '0;
      kidx_q    <= '0;
      key_len_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      acc_q     <= acc_d;
      kidx_q    <= kidx_d;
      key_len_q <= key_len_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    t_q    <= t_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

endmodule

// File: src/rc4_perm_mem.sv
module rc4_perm_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rc4_pkg::perm_req_t             req_i,
  output logic [rc4_pkg::ByteW-1:0]      rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0]     mem_q [PermDepth];
  logic [ByteW-1:0]     rdata_q;
  logic [ByteW-1:0]     raddr_q;
  logic [PermDepth-1:0] vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  // an entry not yet written since the last clear reads as its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[req_i.raddr];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : raddr_q;

endmodule

// File: src/rc4_key_mem.sv
module rc4_key_mem (
  input  logic                      clk_i,
  input  rc4_pkg::key_req_t         req_i,
  output logic [rc4_pkg::ByteW-1:0] rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0] mem_q [KeyDepth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
